@@ design/chip8_instruction_executor_macros.svh @@
// Assertion macros shared by the executor RTL.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_MACROS_SVH
// Implication checked on every rising clock edge, off during reset.
`define C8_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, off during reset.
`define C8_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ design/c8exec_pkg.sv @@
// Shared types and constants for the CHIP-8 executor.
`default_nettype none
package c8exec_pkg;
   localparam int SCREEN_W    = 64;
   localparam int SCREEN_H    = 32;
   localparam int MEM_BYTES   = 4096;
   localparam int STACK_DEPTH = 16;
   localparam int PIX_COUNT   = SCREEN_W * SCREEN_H;
   localparam int PIX_AW      = $clog2(PIX_COUNT);
   localparam int MEM_AW      = $clog2(MEM_BYTES);
   localparam int SP_W        = $clog2(STACK_DEPTH);

   localparam logic [1:0] CMD_EXEC  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_PIX   = 2'd3;

   localparam logic [4:0] OP_RET  = 5'd0;
   localparam logic [4:0] OP_CLS  = 5'd1;
   localparam logic [4:0] OP_JP   = 5'd2;
   localparam logic [4:0] OP_CALL = 5'd3;
   localparam logic [4:0] OP_SEK  = 5'd4;
   localparam logic [4:0] OP_SNEK = 5'd5;
   localparam logic [4:0] OP_SEV  = 5'd6;
   localparam logic [4:0] OP_LDK  = 5'd7;
   localparam logic [4:0] OP_ADDK = 5'd8;
   localparam logic [4:0] OP_MOV  = 5'd9;
   localparam logic [4:0] OP_OR   = 5'd10;
   localparam logic [4:0] OP_AND  = 5'd11;
   localparam logic [4:0] OP_XOR  = 5'd12;
   localparam logic [4:0] OP_ADD  = 5'd13;
   localparam logic [4:0] OP_SUB  = 5'd14;
   localparam logic [4:0] OP_SHR  = 5'd15;
   localparam logic [4:0] OP_SUBN = 5'd16;
   localparam logic [4:0] OP_SHL  = 5'd17;
   localparam logic [4:0] OP_SNEV = 5'd18;
   localparam logic [4:0] OP_LDI  = 5'd19;
   localparam logic [4:0] OP_DRW  = 5'd20;
   localparam logic [4:0] OP_ADDI = 5'd21;
   localparam logic [4:0] OP_BCD  = 5'd22;
   localparam logic [4:0] OP_STR  = 5'd23;
   localparam logic [4:0] OP_LDR  = 5'd24;

   // ALU operation select
   typedef enum logic [2:0] {
      ALU_ADD, ALU_SUB, ALU_OR, ALU_AND, ALU_XOR, ALU_SHR, ALU_SHL, ALU_PASS
   } alu_op_type;

   typedef struct packed {
      logic [7:0] res;
      logic       flag;
   } alu_out_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_EXEC, ST_MEMRD, ST_CLS, ST_DRW_ROW, ST_DRW_RDWAIT,
      ST_DRW_PIX, ST_DRW_PIXWAIT, ST_BCD, ST_RANGE, ST_RANGE_WAIT, ST_DONE
   } state_type;
endpackage
`default_nettype wire

@@ design/c8exec_alu.sv @@
// Shared 8-bit ALU used by the executor's register arithmetic and BCD steps.
`default_nettype none
module c8exec_alu
   import c8exec_pkg::*;
(
   input  wire alu_op_type  op,
   input  wire logic [7:0]  a,
   input  wire logic [7:0]  b,
   output alu_out_type      y
);
   logic [8:0] sum;
   always_comb begin
      sum = 9'd0;
      y   = '{res: 8'd0, flag: 1'b0};
      case (op)
         ALU_ADD: begin
            sum = {1'b0, a} + {1'b0, b};
            y = '{res: sum[7:0], flag: sum[8]};
         end
         ALU_SUB: y = '{res: a - b, flag: (a >= b)};
         ALU_OR:  y = '{res: a | b, flag: 1'b0};
         ALU_AND: y = '{res: a & b, flag: 1'b0};
         ALU_XOR: y = '{res: a ^ b, flag: 1'b0};
         ALU_SHR: y = '{res: {1'b0, b[7:1]}, flag: 1'b0};
         ALU_SHL: y = '{res: {b[6:0], 1'b0}, flag: 1'b0};
         ALU_PASS: y = '{res: b, flag: 1'b0};
         default: y = '{res: 8'd0, flag: 1'b0};
      endcase
   end
endmodule
`default_nettype wire

@@ design/chip8_instruction_executor.sv @@
// CHIP-8 execute unit: registers, stack, memory, framebuffer and sequencer.
// Usage: one command enters on the req_ channel (cmd, op_kind, opcode word,
// address, data); exactly one response leaves on rsp_ carrying PC, I, VF and
// a read value. The block takes one command at a time: req_tready is high
// only while the sequencer is idle and the response register is free.
// Per command the sequencer steps decode then done for a memory write, adds a
// memory-read step for a read and an execute step for simple instructions;
// range store writes the registers in turn, range load reads each one and then
// captures it, BCD runs the shared ALU's repeated subtract, sprite draw reads
// each row byte then each pixel, with a read-XOR-write for on-screen pixels, and
// screen clear writes one pixel a cycle. The next command is taken no earlier
// than the cycle after the response transfers.
// Register arithmetic and the BCD subtraction go through one shared 8-bit
// ALU; memory and framebuffer are single-port arrays with registered reads.
// Reset: synchronous, active high. Registers, I, stack pointer clear, PC goes
// to 0x200, and a clearing pass zeroes all 2048 framebuffer pixels while
// req_tready is low. Memory and stack contents are undefined until written.
// When the receiver stalls, the response holds on rsp_tdata and no new
// command is taken until it has been transferred.
`default_nettype none
`include "chip8_instruction_executor_macros.svh"
module chip8_instruction_executor
   import c8exec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] opcode_word, [27:16] access_address, [35:28] write_byte, pad
   input  wire logic [39:0] req_tdata,
   // [1:0] cmd, [6:2] op_kind
   input  wire logic [6:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [15:0] next_pc, [31:16] index_value, [39:32] flag_value, [47:40] read_value
   output logic [47:0]      rsp_tdata
);
   // command latch
   logic [1:0]  cmd_ff;
   logic [4:0]  kind_ff;
   logic [15:0] word_ff;
   logic [11:0] addr_ff;
   logic [7:0]  wbyte_ff;

   // architectural state
   logic [7:0]      v_ff [16];
   logic [15:0]     i_ff, pc_ff;
   logic [SP_W-1:0] sp_ff;
   logic [15:0]     stack_mem [STACK_DEPTH];
   logic [7:0]      mem [MEM_BYTES];
   logic            fb [PIX_COUNT];

   state_type st_ff, st_in;

   // working registers
   logic [7:0]  a_ff, b_ff, rowbits_ff, rd_ff, dig_ff;
   logic [3:0]  cnt_ff;     // row, register or BCD digit counter
   logic [2:0]  col_ff;     // pixel in row
   logic [PIX_AW-1:0] clr_ff;
   logic        hit_ff, busy_clr_ff;
   logic [1:0]  bstep_ff;   // BCD digit step
   logic [7:0]  bcd_ff;

   logic        rsp_valid_ff;
   logic [47:0] rsp_data_ff;

   // memory port
   logic             mem_we;
   logic [MEM_AW-1:0] mem_addr;
   logic [7:0]       mem_wd, mem_rd_ff;
   // framebuffer port
   logic             fb_we;
   logic [PIX_AW-1:0] fb_addr;
   logic             fb_wd, fb_rd_ff;

   // alu
   alu_op_type  alu_op;
   logic [7:0]  alu_a, alu_b;
   alu_out_type alu_y;

   c8exec_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

   logic [3:0] fx, fy;
   assign fx = word_ff[11:8];
   assign fy = word_ff[7:4];

   // sprite pixel coordinates
   logic [7:0] pcol, prow;
   logic       pin;
   logic [PIX_AW-1:0] ppos;
   assign pcol = a_ff + {5'd0, col_ff};
   assign prow = b_ff + {4'd0, cnt_ff};
   assign pin  = (pcol < 8'(SCREEN_W)) && (prow < 8'(SCREEN_H));
   assign ppos = PIX_AW'((SCREEN_H - 1 - int'(prow)) * SCREEN_W + int'(pcol));
   logic pbit;
   assign pbit = rowbits_ff[3'd7 - col_ff];

   logic [15:0] i_plus;
   assign i_plus = i_ff + {12'd0, cnt_ff};

   assign req_tready = (st_ff == ST_IDLE) && !rsp_valid_ff && !busy_clr_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_addr];
      if (fb_we) begin
         fb[fb_addr] <= fb_wd;
      end
      fb_rd_ff <= fb[fb_addr];
   end

   // next state and port control
   always_comb begin
      st_in    = st_ff;
      mem_we   = 1'b0;
      mem_addr = addr_ff[MEM_AW-1:0];
      mem_wd   = wbyte_ff;
      fb_we    = 1'b0;
      fb_addr  = addr_ff[PIX_AW-1:0];
      fb_wd    = 1'b0;
      alu_op   = ALU_PASS;
      alu_a    = a_ff;
      alu_b    = b_ff;
      if (busy_clr_ff) begin
         fb_we   = 1'b1;
         fb_addr = clr_ff;
      end
      case (st_ff)
         ST_IDLE: if (req_tvalid && req_tready) st_in = ST_DECODE;
         ST_DECODE: begin
            case (cmd_ff)
               CMD_WRITE: begin
                  mem_we = 1'b1;
                  st_in  = ST_DONE;
               end
               CMD_READ, CMD_PIX: st_in = ST_MEMRD;
               default: begin
                  case (kind_ff)
                     OP_CLS: st_in = ST_CLS;
                     OP_DRW: st_in = (word_ff[3:0] == 4'd0) ? ST_EXEC : ST_DRW_ROW;
                     OP_BCD: st_in = ST_BCD;
                     OP_STR, OP_LDR: st_in = ST_RANGE;
                     default: st_in = ST_EXEC;
                  endcase
               end
            endcase
         end
         ST_MEMRD: st_in = ST_DONE;
         ST_EXEC: begin
            case (kind_ff)
               OP_ADDK: begin alu_op = ALU_ADD; alu_b = word_ff[7:0]; end
               OP_ADD:  alu_op = ALU_ADD;
               OP_SUB:  alu_op = ALU_SUB;
               OP_SUBN: begin alu_op = ALU_SUB; alu_a = b_ff; alu_b = a_ff; end
               OP_OR:   alu_op = ALU_OR;
               OP_AND:  alu_op = ALU_AND;
               OP_XOR:  alu_op = ALU_XOR;
               OP_SHR:  alu_op = ALU_SHR;
               OP_SHL:  alu_op = ALU_SHL;
               default: alu_op = ALU_PASS;
            endcase
            st_in = ST_DONE;
         end
         ST_CLS: begin
            fb_we   = 1'b1;
            fb_addr = clr_ff;
            if (clr_ff == PIX_AW'(PIX_COUNT - 1)) st_in = ST_EXEC;
         end
         ST_DRW_ROW: begin
            mem_addr = i_plus[MEM_AW-1:0];
            st_in    = ST_DRW_RDWAIT;
         end
         ST_DRW_RDWAIT: st_in = ST_DRW_PIX;
         ST_DRW_PIX: begin
            fb_addr = ppos;
            st_in   = pin ? ST_DRW_PIXWAIT : ST_DRW_PIX;
            if (!pin && col_ff == 3'd7) begin
               st_in = (cnt_ff == word_ff[3:0] - 4'd1) ? ST_EXEC : ST_DRW_ROW;
            end
         end
         ST_DRW_PIXWAIT: begin
            fb_addr = ppos;
            fb_we   = 1'b1;
            fb_wd   = fb_rd_ff ^ pbit;
            if (col_ff == 3'd7) begin
               st_in = (cnt_ff == word_ff[3:0] - 4'd1) ? ST_EXEC : ST_DRW_ROW;
            end else begin
               st_in = ST_DRW_PIX;
            end
         end
         ST_BCD: begin
            // repeated subtraction through the shared ALU
            alu_op = ALU_SUB;
            alu_a  = bcd_ff;
            alu_b  = (bstep_ff == 2'd0) ? 8'd100 : 8'd10;
            mem_addr = i_plus[MEM_AW-1:0];
            mem_wd   = dig_ff;
            if (bstep_ff == 2'd2) begin
               mem_wd = bcd_ff;
               mem_we = 1'b1;
               st_in  = ST_EXEC;
            end else if (!alu_y.flag) begin
               mem_we = 1'b1;
            end
         end
         ST_RANGE: begin
            mem_addr = i_ff[MEM_AW-1:0];
            mem_wd   = v_ff[cnt_ff];
            mem_we   = (kind_ff == OP_STR);
            st_in    = (kind_ff == OP_STR) ?
                       ((cnt_ff == fx) ? ST_EXEC : ST_RANGE) : ST_RANGE_WAIT;
         end
         ST_RANGE_WAIT: st_in = (cnt_ff == fx) ? ST_EXEC : ST_RANGE;
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // sequencer datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 16; k++) v_ff[k] <= 8'd0;
         i_ff         <= 16'd0;
         pc_ff        <= 16'h0200;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         busy_clr_ff  <= 1'b1;
         clr_ff       <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         if (busy_clr_ff) begin
            clr_ff <= clr_ff + PIX_AW'(1);
            if (clr_ff == PIX_AW'(PIX_COUNT - 1)) busy_clr_ff <= 1'b0;
         end
         case (st_ff)
            ST_IDLE: begin
               if (req_tvalid && req_tready) begin
                  cmd_ff   <= req_tuser[1:0];
                  kind_ff  <= req_tuser[6:2];
                  word_ff  <= req_tdata[15:0];
                  addr_ff  <= req_tdata[27:16];
                  wbyte_ff <= req_tdata[35:28];
                  rd_ff    <= 8'd0;
               end
            end
            ST_DECODE: begin
               a_ff     <= v_ff[fx];
               b_ff     <= v_ff[fy];
               bcd_ff   <= v_ff[fx];
               dig_ff   <= 8'd0;
               bstep_ff <= 2'd0;
               cnt_ff   <= 4'd0;
               col_ff   <= 3'd0;
               hit_ff   <= 1'b0;
               clr_ff   <= '0;
            end
            ST_MEMRD: begin
               if (cmd_ff == CMD_READ) begin
                  rd_ff <= mem_rd_ff;
               end else begin
                  rd_ff <= (int'(addr_ff) < PIX_COUNT) ? {7'd0, fb_rd_ff} : 8'd0;
               end
            end
            ST_CLS: clr_ff <= clr_ff + PIX_AW'(1);
            ST_DRW_RDWAIT: rowbits_ff <= mem_rd_ff;
            ST_DRW_PIX: begin
               if (!pin) begin
                  col_ff <= col_ff + 3'd1;
                  if (col_ff == 3'd7) cnt_ff <= cnt_ff + 4'd1;
               end
            end
            ST_DRW_PIXWAIT: begin
               if (pbit && fb_rd_ff) hit_ff <= 1'b1;
               col_ff <= col_ff + 3'd1;
               if (col_ff == 3'd7) cnt_ff <= cnt_ff + 4'd1;
            end
            ST_BCD: begin
               if (bstep_ff != 2'd2) begin
                  if (alu_y.flag) begin
                     bcd_ff <= alu_y.res;
                     dig_ff <= dig_ff + 8'd1;
                  end else begin
                     dig_ff   <= 8'd0;
                     bstep_ff <= bstep_ff + 2'd1;
                     cnt_ff   <= cnt_ff + 4'd1;
                  end
               end
            end
            ST_RANGE: begin
               i_ff <= i_ff + 16'd1;
               if (kind_ff == OP_STR) cnt_ff <= cnt_ff + 4'd1;
            end
            ST_RANGE_WAIT: begin
               v_ff[cnt_ff] <= mem_rd_ff;
               cnt_ff <= cnt_ff + 4'd1;
            end
            ST_EXEC: begin
               if (cmd_ff == CMD_EXEC) begin
                  pc_ff <= pc_ff + 16'd2;
                  case (kind_ff)
                     OP_RET: begin
                        pc_ff <= stack_mem[sp_ff - SP_W'(1)] + 16'd2;
                        sp_ff <= sp_ff - SP_W'(1);
                     end
                     OP_JP: pc_ff <= {4'd0, word_ff[11:0]};
                     OP_CALL: begin
                        stack_mem[sp_ff] <= pc_ff;
                        sp_ff <= sp_ff + SP_W'(1);
                        pc_ff <= {4'd0, word_ff[11:0]};
                     end
                     OP_SEK:  if (a_ff == word_ff[7:0]) pc_ff <= pc_ff + 16'd4;
                     OP_SNEK: if (a_ff != word_ff[7:0]) pc_ff <= pc_ff + 16'd4;
                     OP_SEV:  if (a_ff == b_ff) pc_ff <= pc_ff + 16'd4;
                     OP_SNEV: if (a_ff != b_ff) pc_ff <= pc_ff + 16'd4;
                     OP_LDK:  v_ff[fx] <= word_ff[7:0];
                     OP_ADDK, OP_MOV, OP_OR, OP_AND, OP_XOR, OP_SHR, OP_SHL:
                        v_ff[fx] <= alu_y.res;
                     OP_ADD, OP_SUB, OP_SUBN: begin
                        v_ff[fx] <= alu_y.res;
                        v_ff[15] <= {7'd0, alu_y.flag};
                     end
                     OP_LDI:  i_ff <= {4'd0, word_ff[11:0]};
                     OP_ADDI: i_ff <= i_ff + {8'd0, a_ff};
                     OP_DRW:  v_ff[15] <= {7'd0, hit_ff};
                     default: ;
                  endcase
               end
            end
            ST_DONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= {rd_ff, v_ff[15], i_ff, pc_ff};
            end
            default: ;
         endcase
      end
   end

   // EXEC always hands off to DONE; non-execute commands pass DONE too
   logic unused_ok;
   assign unused_ok = ^{req_tdata[39:36]};

   `C8_ASSERT_NXT(a_done_rsp, clock, reset, st_ff == ST_DONE, rsp_tvalid,
      "response not raised after DONE")
   `C8_ASSERT_IMP(a_busy_noready, clock, reset, st_ff != ST_IDLE, !req_tready,
      "ready while sequencer busy")
   `C8_ASSERT_IMP(a_clr_noready, clock, reset, busy_clr_ff, !req_tready,
      "ready during clearing pass")
   `C8_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_tvalid,
      st_ff == ST_IDLE || st_ff == ST_DECODE,
      "sequencer ran past idle with response pending")
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the CHIP-8 execute unit: predicts every response from a local machine model.
`default_nettype none
module testbench;
   import c8exec_pkg::*;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [4:0]  kind;
      logic [15:0] word;
      logic [11:0] addr;
      logic [7:0]  data;
   } command_type;

   // packed to match rsp_tdata: next_pc in the lowest bits
   typedef struct packed {
      logic [7:0]  rdv;
      logic [7:0]  vf;
      logic [15:0] idx;
      logic [15:0] pc;
   } status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [6:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   chip8_instruction_executor u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // machine model
   logic [7:0]  v_reg [16];
   logic [15:0] i_reg;
   logic [15:0] pc_reg;
   logic [3:0]  sp_reg;
   logic [15:0] stk [16];
   logic [7:0]  mem [MEM_BYTES];
   logic        fb [PIX_COUNT];

   command_type pending_cmds[$];
   status_type  expected_status[$];
   int       errors = 0;
   bit       stim_done = 0;
   bit       hold_rsp = 0;

   // Expected machine status after one accepted command.
   function automatic status_type execute_command(command_type c);
      logic [3:0]  x, y;
      logic [7:0]  kk, a, b, rb, col, row, rdv;
      logic [15:0] nnn;
      logic        adv, hit, bit_v;
      int          pos;
      status_type  s;
      x = c.word[11:8]; y = c.word[7:4]; kk = c.word[7:0]; nnn = {4'h0, c.word[11:0]};
      a = v_reg[x]; b = v_reg[y]; adv = 1'b1; rdv = 8'h00;
      case (c.cmd)
         CMD_WRITE: mem[c.addr] = c.data;
         CMD_READ: rdv = mem[c.addr];
         CMD_PIX: rdv = (c.addr < PIX_COUNT) ? {7'd0, fb[c.addr]} : 8'h00;
         default: begin
            case (c.kind)
               OP_RET: begin
                  sp_reg = sp_reg - 4'd1;
                  pc_reg = stk[sp_reg];
               end
               OP_CLS: for (int p = 0; p < PIX_COUNT; p++) fb[p] = 1'b0;
               OP_JP: begin
                  pc_reg = nnn; adv = 1'b0;
               end
               OP_CALL: begin
                  stk[sp_reg] = pc_reg; sp_reg = sp_reg + 4'd1;
                  pc_reg = nnn; adv = 1'b0;
               end
               OP_SEK: if (a == kk) pc_reg += 16'd2;
               OP_SNEK: if (a != kk) pc_reg += 16'd2;
               OP_SEV: if (a == b) pc_reg += 16'd2;
               OP_LDK: v_reg[x] = kk;
               OP_ADDK: v_reg[x] = a + kk;
               OP_MOV: v_reg[x] = b;
               OP_OR: v_reg[x] = a | b;
               OP_AND: v_reg[x] = a & b;
               OP_XOR: v_reg[x] = a ^ b;
               OP_ADD: begin
                  v_reg[x] = a + b;
                  v_reg[15] = ({1'b0, a} + {1'b0, b} > 9'd255) ? 8'h01 : 8'h00;
               end
               OP_SUB: begin
                  v_reg[x] = a - b;
                  v_reg[15] = (a >= b) ? 8'h01 : 8'h00;
               end
               OP_SHR: v_reg[x] = b >> 1;
               OP_SUBN: begin
                  v_reg[x] = b - a;
                  v_reg[15] = (b >= a) ? 8'h01 : 8'h00;
               end
               OP_SHL: v_reg[x] = b << 1;
               OP_SNEV: if (a != b) pc_reg += 16'd2;
               OP_LDI: i_reg = nnn;
               OP_DRW: begin
                  hit = 1'b0;
                  for (int r = 0; r < c.word[3:0]; r++) begin
                     rb = mem[12'(i_reg + 16'(r))];
                     for (int j = 0; j < 8; j++) begin
                        col = a + 8'(j);
                        row = b + 8'(r);
                        if (col < SCREEN_W && row < SCREEN_H) begin
                           pos = SCREEN_W * (SCREEN_H - 1 - row) + col;
                           bit_v = rb[7 - j];
                           if (bit_v && fb[pos]) hit = 1'b1;
                           fb[pos] = fb[pos] ^ bit_v;
                        end
                     end
                  end
                  v_reg[15] = {7'd0, hit};
               end
               OP_ADDI: i_reg = i_reg + {8'd0, a};
               OP_BCD: begin
                  mem[12'(i_reg)] = a / 100;
                  mem[12'(i_reg + 16'd1)] = (a / 10) % 10;
                  mem[12'(i_reg + 16'd2)] = a % 10;
               end
               OP_STR: for (int r = 0; r <= x; r++) begin
                  mem[12'(i_reg)] = v_reg[r]; i_reg += 16'd1;
               end
               OP_LDR: for (int r = 0; r <= x; r++) begin
                  v_reg[r] = mem[12'(i_reg)]; i_reg += 16'd1;
               end
               default: ;
            endcase
            if (adv) pc_reg += 16'd2;
         end
      endcase
      s.pc = pc_reg; s.idx = i_reg; s.vf = v_reg[15]; s.rdv = rdv;
      return s;
   endfunction

   // Tracking of written memory/stack so that reads stay in contract.
   bit       mem_known [MEM_BYTES];
   int       depth_calls = 0;
   logic [15:0] plan_i = 0;

   function automatic command_type make_cmd(logic [1:0] cm, logic [4:0] k, logic [15:0] w,
                                            logic [11:0] ad, logic [7:0] d);
      command_type c;
      c.cmd = cm; c.kind = k; c.word = w; c.addr = ad; c.data = d;
      return c;
   endfunction

   // Queue a command, tracking planned I (registers VX unknown for ADDI -> avoided).
   task automatic push_cmd(command_type c);
      if (c.cmd == CMD_WRITE) mem_known[c.addr] = 1;
      if (c.cmd == CMD_EXEC) begin
         case (c.kind)
            OP_CALL: depth_calls++;
            OP_RET: depth_calls--;
            OP_LDI: plan_i = {4'h0, c.word[11:0]};
            OP_BCD: for (int k = 0; k < 3; k++) mem_known[12'(plan_i + 16'(k))] = 1;
            OP_STR: for (int k = 0; k <= c.word[11:8]; k++) begin
               mem_known[12'(plan_i)] = 1; plan_i += 16'd1;
            end
            OP_LDR: plan_i += 16'(c.word[11:8]) + 16'd1;
            default: ;
         endcase
      end
      pending_cmds.push_back(c);
   endtask

   // Fill a memory range with random bytes.
   task automatic fill_mem(logic [11:0] base, int n);
      for (int k = 0; k < n; k++)
         push_cmd(make_cmd(CMD_WRITE, 5'd0, 16'($urandom), base + 12'(k), 8'($urandom)));
   endtask

   task automatic random_item();
      int          pick;
      logic [15:0] w;
      logic [11:0] ad;
      logic [4:0]  k;
      pick = $urandom_range(0, 99);
      w = 16'($urandom);
      ad = 12'($urandom);
      if (pick < 8) begin
         push_cmd(make_cmd(CMD_WRITE, 5'($urandom), w, ad, 8'($urandom)));
      end else if (pick < 16) begin
         if (!mem_known[ad]) push_cmd(make_cmd(CMD_WRITE, 5'd0, w, ad, 8'($urandom)));
         push_cmd(make_cmd(CMD_READ, 5'($urandom), w, ad, 8'($urandom)));
      end else if (pick < 24) begin
         push_cmd(make_cmd(CMD_PIX, 5'($urandom), w, ($urandom_range(0, 9) == 0) ? ad
                           : 12'($urandom_range(0, PIX_COUNT - 1)), 8'($urandom)));
      end else if (pick < 30) begin
         // sprite: fresh I then draw with bytes made known
         ad = 12'($urandom);
         push_cmd(make_cmd(CMD_EXEC, OP_LDI, {4'hA, ad}, 12'($urandom), 8'($urandom)));
         w[3:0] = ($urandom_range(0, 7) == 0) ? 4'd15 : 4'($urandom_range(0, 5));
         for (int r = 0; r < w[3:0]; r++)
            if (!mem_known[ad + 12'(r)])
               push_cmd(make_cmd(CMD_WRITE, 5'd0, 16'd0, ad + 12'(r), 8'($urandom)));
         push_cmd(make_cmd(CMD_EXEC, OP_DRW, w, 12'($urandom), 8'($urandom)));
      end else if (pick < 34) begin
         ad = 12'($urandom);
         push_cmd(make_cmd(CMD_EXEC, OP_LDI, {4'hA, ad}, 12'($urandom), 8'($urandom)));
         k = ($urandom_range(0, 1) == 0) ? OP_BCD : OP_STR;
         if ($urandom_range(0, 3) == 0) begin
            // load only what is known
            w[11:8] = 4'($urandom_range(0, 15));
            for (int r = 0; r <= w[11:8]; r++)
               if (!mem_known[ad + 12'(r)])
                  push_cmd(make_cmd(CMD_WRITE, 5'd0, 16'd0, ad + 12'(r), 8'($urandom)));
            k = OP_LDR;
         end
         push_cmd(make_cmd(CMD_EXEC, k, w, 12'($urandom), 8'($urandom)));
      end else if (pick < 40) begin
         if (depth_calls > 0 && $urandom_range(0, 1) == 0)
            push_cmd(make_cmd(CMD_EXEC, OP_RET, w, ad, 8'($urandom)));
         else
            push_cmd(make_cmd(CMD_EXEC, OP_CALL, w, ad, 8'($urandom)));
      end else if (pick < 41) begin
         push_cmd(make_cmd(CMD_EXEC, OP_CLS, w, ad, 8'($urandom)));
      end else begin
         // ALU, skips, jumps, index ops and undefined kinds
         do k = 5'($urandom); while (k == OP_RET || k == OP_CALL || k == OP_CLS ||
                                      k == OP_DRW || k == OP_BCD || k == OP_STR ||
                                      k == OP_LDR || k == OP_LDI || k == OP_ADDI);
         if ($urandom_range(0, 9) == 0) k = OP_LDI;
         if ($urandom_range(0, 19) == 0) k = OP_ADDI;
         if (k == OP_ADDI) plan_i = 16'hxxxx;
         push_cmd(make_cmd(CMD_EXEC, k, w, ad, 8'($urandom)));
      end
   endtask

   // ADDI makes planned I unknown; re-establish it before memory ops use it.
   initial begin
      for (int k = 0; k < MEM_BYTES; k++) mem_known[k] = 0;
      // directed: extremes, every kind, wrap cases
      fill_mem(12'hFFE, 2);
      push_cmd(make_cmd(CMD_READ, OP_RET, 16'hFFFF, 12'hFFF, 8'hFF));
      push_cmd(make_cmd(CMD_EXEC, OP_LDK, 16'h60FF, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_LDK, 16'h6101, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_ADD, 16'h8014, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_SUB, 16'h8F14, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_SUBN, 16'h8017, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_LDI, 16'hAFFE, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_BCD, 16'hF133, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_LDI, 16'hAFFE, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_STR, 16'hFF55, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_LDI, 16'hAFFE, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_LDR, 16'hF565, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_LDK, 16'h623C, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_LDK, 16'h631C, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_LDI, 16'hAFFE, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_DRW, 16'hD23F, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_DRW, 16'hD23F, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_PIX, 5'd0, 16'd0, 12'd2047, 8'd0));
      push_cmd(make_cmd(CMD_PIX, 5'd0, 16'd0, 12'hFFF, 8'd0));
      for (int k = 0; k < 17; k++)
         push_cmd(make_cmd(CMD_EXEC, OP_CALL, 16'h2000 | 16'(k * 8), 12'd0, 8'd0));
      for (int k = 0; k < 17; k++)
         push_cmd(make_cmd(CMD_EXEC, OP_RET, 16'h00EE, 12'd0, 8'd0));
      for (int k = 0; k < 32; k++) begin
         // memory kinds run from the block written above
         if (5'(k) == OP_BCD || 5'(k) == OP_STR || 5'(k) == OP_LDR)
            push_cmd(make_cmd(CMD_EXEC, OP_LDI, 16'hAFFE, 12'd0, 8'd0));
         push_cmd(make_cmd(CMD_EXEC, 5'(k), 16'h3F00, 12'd0, 8'd0));
      end
      push_cmd(make_cmd(CMD_EXEC, OP_JP, 16'h1FFF, 12'd0, 8'd0));
      push_cmd(make_cmd(CMD_EXEC, OP_ADDI, 16'hF01E, 12'd0, 8'd0));
      plan_i = 16'hxxxx;
      push_cmd(make_cmd(CMD_EXEC, OP_CLS, 16'h00E0, 12'd0, 8'd0));
      // random part
      while (pending_cmds.size() < 1900) begin
         if ($isunknown(plan_i))
            push_cmd(make_cmd(CMD_EXEC, OP_LDI, 16'hA000 | 16'($urandom_range(0, 4095)),
                              12'd0, 8'd0));
         random_item();
      end
      stim_done = 1;
   end

   // request driver
   int gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_status.push_back(execute_command(pending_cmds.pop_front()));
         end
         if (!(req_tvalid && !req_tready)) begin
            if (gap > 0) begin
               gap <= gap - 1;
               req_tvalid <= 1'b0;
            end else if ((req_tvalid && req_tready ? pending_cmds.size() > 0
                          : pending_cmds.size() > 0)) begin
               req_tvalid <= 1'b1;
               req_tuser <= {pending_cmds[0].kind, pending_cmds[0].cmd};
               req_tdata <= {4'd0, pending_cmds[0].data, pending_cmds[0].addr,
                             pending_cmds[0].word};
               if (!hold_rsp && $urandom_range(0, 3) == 0)
                  gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                         : $urandom_range(0, 2);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random stalls and one long hold-off
   int stall = 0;
   int rsp_count = 0;
   always @(posedge clock) begin
      status_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            rsp_count <= rsp_count + 1;
            if (expected_status.size() == 0) begin
               $display("%0t unexpected response %h", $time, got);
               errors++;
            end else begin
               want = expected_status.pop_front();
               if (got.pc !== want.pc)
                  $display("%0t next_pc exp %h got %h", $time, want.pc, got.pc);
               if (got.idx !== want.idx)
                  $display("%0t index_value exp %h got %h", $time, want.idx, got.idx);
               if (got.vf !== want.vf)
                  $display("%0t flag_value exp %h got %h", $time, want.vf, got.vf);
               if (got.rdv !== want.rdv)
                  $display("%0t read_value exp %h got %h", $time, want.rdv, got.rdv);
               if (got !== want) errors++;
            end
         end
         if (rsp_count == 200 && !hold_rsp && stall == 0) begin
            hold_rsp <= 1;
            stall <= 300;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall <= stall - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // state init, reset, watchdog and end of run
   int idle_cycles = 0;
   initial begin
      for (int k = 0; k < 16; k++) begin
         v_reg[k] = 8'd0; stk[k] = 16'd0;
      end
      for (int k = 0; k < MEM_BYTES; k++) mem[k] = 8'd0;
      for (int k = 0; k < PIX_COUNT; k++) fb[k] = 1'b0;
      i_reg = 16'd0; pc_reg = 16'h0200; sp_reg = 4'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 20000) begin
            $display("RESULT: ERROR");
            $finish;
         end
         if (stim_done && pending_cmds.size() == 0 && !req_tvalid &&
             expected_status.size() == 0) begin
            repeat (300) @(posedge clock);
            if (errors == 0 && !rsp_tvalid) $display("RESULT: OK");
            else $display("RESULT: ERROR");
            $finish;
         end
      end
   end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+design
design/c8exec_pkg.sv
design/c8exec_alu.sv
design/chip8_instruction_executor.sv
tb/testbench.sv
